FILE: rtl/tbrl_pkg.sv
// ============================================================================
// tbrl_pkg: shared definitions for the token bucket rate limiter
// Field widths, register indexes, reset values and divider handshake types.
// ============================================================================
package tbrl_pkg;

  // Bucket sizing: the count saturates at 2^(TOKEN_BITS-1)-1
  localparam int TOKEN_BITS = 32;
  localparam int BKT_W      = TOKEN_BITS - 1;

  // Field and register widths
  localparam int AMOUNT_W    = 31;
  localparam int INIT_W      = 31;
  localparam int LIMIT_W     = 31;
  localparam int REFILL_W    = 16;
  localparam int INTERVAL_W  = 32;
  localparam int MIN_RETRY_W = 32;
  localparam int RETRY_W     = 48;
  localparam int LEVEL_W     = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 3;

  // Compare width wide enough for bucket, amount, limit and bucket plus refill
  localparam int CMP_W = ((BKT_W > AMOUNT_W) ? BKT_W : AMOUNT_W) + 1;

  // Retry product and serial divider geometry
  localparam int PROD_W         = AMOUNT_W + INTERVAL_W;
  localparam int DIV_W          = 64;
  localparam int DIVISOR_W      = REFILL_W;
  localparam int DIV_RADIX_BITS = 2;
  localparam int DIV_CYCLES     = DIV_W / DIV_RADIX_BITS;
  localparam int DIV_CNT_W      = $clog2(DIV_CYCLES);

  localparam logic [BKT_W-1:0]   TOKEN_MAX = '1;
  localparam logic [RETRY_W-1:0] RETRY_MAX = '1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_LEVEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REFILL_AMOUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_TICKS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RETRY_TICKS = 3'd4;

  // Register reset values
  localparam logic [LIMIT_W-1:0]     LIMIT_RST     = 31'd1024;
  localparam logic [REFILL_W-1:0]    REFILL_RST    = 16'd1;
  localparam logic [INTERVAL_W-1:0]  INTERVAL_RST  = 32'd1000;
  localparam logic [MIN_RETRY_W-1:0] MIN_RETRY_RST = 32'd0;

  // Item kinds
  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  // Divider request and response
  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: rtl/tbrl_in_if.sv
// ============================================================================
// tbrl_in_if: input item channel
// Valid/ready channel carrying one tick or token request per transfer.
// ============================================================================
interface tbrl_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [tbrl_pkg::AMOUNT_W-1:0] amount;

  modport source (output valid, kind, amount, input ready);
  modport sink   (input valid, kind, amount, output ready);
endinterface

FILE: rtl/tbrl_out_if.sv
// ============================================================================
// tbrl_out_if: result channel
// Valid/ready channel carrying one grant decision per transfer.
// ============================================================================
interface tbrl_out_if;
  logic                                valid;
  logic                                ready;
  logic                                granted;
  logic [tbrl_pkg::RETRY_W-1:0]        retry_after;
  logic signed [tbrl_pkg::LEVEL_W-1:0] level;

  modport source (output valid, granted, retry_after, level, input ready);
  modport sink   (input valid, granted, retry_after, level, output ready);
endinterface

FILE: rtl/tbrl_div.sv
// ============================================================================
// tbrl_div: serial unsigned divider
// Restoring division, two quotient bits per cycle, quotient shifted into the
// dividend register. A done pulse follows the last step.
// ============================================================================
module tbrl_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tbrl_pkg::div_req_t req_i,
  output tbrl_pkg::div_rsp_t rsp_o
);

  localparam logic [tbrl_pkg::DIV_CNT_W-1:0] DIV_LAST =
    tbrl_pkg::DIV_CNT_W'(tbrl_pkg::DIV_CYCLES - 1);

  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic [tbrl_pkg::DIV_CNT_W-1:0]     cnt_q, cnt_d;
  logic [tbrl_pkg::DIVISOR_W-1:0]     rem_q, rem_d;
  logic [tbrl_pkg::DIVISOR_W-1:0]     dvs_q, dvs_d;
  logic [tbrl_pkg::DIV_W-1:0]         dvd_q, dvd_d;
  logic [tbrl_pkg::DIVISOR_W-1:0]     rem_step;
  logic [tbrl_pkg::DIV_W-1:0]         dvd_step;

  // Run the restoring steps of one cycle
  always_comb begin
    logic [tbrl_pkg::DIVISOR_W:0] trial;
    logic                         qbit;
    rem_step = rem_q;
    dvd_step = dvd_q;
    for (int i = 0; i < tbrl_pkg::DIV_RADIX_BITS; i++) begin
      trial = {rem_step, dvd_step[tbrl_pkg::DIV_W-1]};
      if (trial >= {1'b0, dvs_q}) begin
        trial = trial - {1'b0, dvs_q};
        qbit  = 1'b1;
      end else begin
        qbit  = 1'b0;
      end
      rem_step = trial[tbrl_pkg::DIVISOR_W-1:0];
      dvd_step = {dvd_step[tbrl_pkg::DIV_W-2:0], qbit};
    end
  end

  // Sequence load, steps and done pulse
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    dvd_d  = dvd_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      dvd_d  = req_i.dividend;
    end else if (busy_q) begin
      rem_d = rem_step;
      dvd_d = dvd_step;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold operands and partial results
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    dvd_q <= dvd_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !req_i.start && cnt_q == DIV_LAST) |=> (done_q && !busy_q))
    else $error("divider missed its done pulse");

  a_done_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");

endmodule

FILE: rtl/token_bucket_rate_limiter_unit.sv
// ============================================================================
// token_bucket_rate_limiter_unit: token bucket with retry delay reporting
// Ticks refill the bucket once per interval; requests are granted or denied.
// ============================================================================
// Ticks and granted requests: result valid in the cycle after the input transfer,
//   one item per cycle while the result side keeps up.
// Denied requests: a multiply state, a divider load, the steps of the
//   2-bit-per-cycle serial divider, its done pulse and the result register;
//   the result follows the multiply state when the refill amount is zero. Input not ready.
// Reset: bucket and elapsed counter cleared, registers at their reset values.
module token_bucket_rate_limiter_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tbrl_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tbrl_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  tbrl_in_if.sink                          in_i,
  tbrl_out_if.source                       out_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV
  } state_e;

  localparam int CMP_W = tbrl_pkg::CMP_W;
  localparam int BKT_W = tbrl_pkg::BKT_W;

  state_e                                state_q, state_d;
  logic [BKT_W-1:0]                      bucket_q, bucket_d;
  logic [tbrl_pkg::INTERVAL_W-1:0]       elapsed_q, elapsed_d;
  logic [tbrl_pkg::LIMIT_W-1:0]          limit_q, limit_d;
  logic [tbrl_pkg::REFILL_W-1:0]         refill_q, refill_d;
  logic [tbrl_pkg::INTERVAL_W-1:0]       interval_q, interval_d;
  logic [tbrl_pkg::MIN_RETRY_W-1:0]      min_retry_q, min_retry_d;
  logic [tbrl_pkg::AMOUNT_W-1:0]         short_q, short_d;
  logic [tbrl_pkg::PROD_W-1:0]           prod_q, prod_d;
  logic                                  div_start_q, div_start_d;
  logic                                  out_valid_q, out_valid_d;
  logic                                  granted_q, granted_d;
  logic [tbrl_pkg::RETRY_W-1:0]          retry_q, retry_d;
  logic signed [tbrl_pkg::LEVEL_W-1:0]   level_q, level_d;
  logic                                  in_ready;
  logic [tbrl_pkg::INTERVAL_W-1:0]       elapsed_inc;
  tbrl_pkg::div_req_t                    div_req;
  tbrl_pkg::div_rsp_t                    div_rsp;

  // Add one interval of tokens, capped at the limit and bucket ceiling; a bucket over the limit is kept
  function automatic logic [BKT_W-1:0] refill_level(
    input logic [BKT_W-1:0]              b,
    input logic [tbrl_pkg::LIMIT_W-1:0]  lim,
    input logic [tbrl_pkg::REFILL_W-1:0] add
  );
    logic [CMP_W-1:0] sum;
    logic [CMP_W-1:0] cap;
    sum = CMP_W'(b) + CMP_W'(add);
    cap = CMP_W'(lim);
    if (cap > CMP_W'(tbrl_pkg::TOKEN_MAX)) begin
      cap = CMP_W'(tbrl_pkg::TOKEN_MAX);
    end
    if (CMP_W'(b) > CMP_W'(lim)) begin
      return b;
    end
    if (sum > cap) begin
      sum = cap;
    end
    return BKT_W'(sum);
  endfunction

  function automatic logic signed [tbrl_pkg::LEVEL_W-1:0] level_of(
    input logic [BKT_W-1:0] b
  );
    return $signed(tbrl_pkg::LEVEL_W'(b));
  endfunction

  assign in_ready    = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign elapsed_inc = elapsed_q + 1'b1;

  // Next-state and datapath control
  always_comb begin
    state_d     = state_q;
    bucket_d    = bucket_q;
    elapsed_d   = elapsed_q;
    limit_d     = limit_q;
    refill_d    = refill_q;
    interval_d  = interval_q;
    min_retry_d = min_retry_q;
    short_d     = short_q;
    prod_d      = prod_q;
    div_start_d = 1'b0;
    out_valid_d = out_valid_q;
    granted_d   = granted_q;
    retry_d     = retry_q;
    level_d     = level_q;

    // Drop the held result once it transfers
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    // Register writes
    if (cfg_we_i) begin
      case (cfg_idx_i)
        tbrl_pkg::CFG_INITIAL_LEVEL: begin
          if (CMP_W'(cfg_wdata_i[tbrl_pkg::INIT_W-1:0]) >
              CMP_W'(tbrl_pkg::TOKEN_MAX)) begin
            bucket_d = tbrl_pkg::TOKEN_MAX;
          end else begin
            bucket_d = BKT_W'(cfg_wdata_i[tbrl_pkg::INIT_W-1:0]);
          end
        end
        tbrl_pkg::CFG_BUCKET_LIMIT:    limit_d     = cfg_wdata_i[tbrl_pkg::LIMIT_W-1:0];
        tbrl_pkg::CFG_REFILL_AMOUNT:   refill_d    = cfg_wdata_i[tbrl_pkg::REFILL_W-1:0];
        tbrl_pkg::CFG_INTERVAL_TICKS:  interval_d  = cfg_wdata_i[tbrl_pkg::INTERVAL_W-1:0];
        tbrl_pkg::CFG_MIN_RETRY_TICKS: min_retry_d = cfg_wdata_i[tbrl_pkg::MIN_RETRY_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid && in_ready) begin
          if (in_i.kind == tbrl_pkg::KIND_TICK) begin
            // Advance elapsed and refill at the end of the interval
            logic [BKT_W-1:0] nb;
            nb = bucket_q;
            if (elapsed_inc >= interval_q || elapsed_inc == '0) begin
              elapsed_d = '0;
              nb        = refill_level(bucket_q, limit_q, refill_q);
            end else begin
              elapsed_d = elapsed_inc;
            end
            bucket_d    = nb;
            out_valid_d = 1'b1;
            granted_d   = 1'b0;
            retry_d     = '0;
            level_d     = level_of(nb);
          end else if (CMP_W'(in_i.amount) <= CMP_W'(bucket_q)) begin
            // Grant and remove the tokens
            logic [BKT_W-1:0] nb;
            nb          = BKT_W'(CMP_W'(bucket_q) - CMP_W'(in_i.amount));
            bucket_d    = nb;
            out_valid_d = 1'b1;
            granted_d   = 1'b1;
            retry_d     = '0;
            level_d     = level_of(nb);
          end else begin
            // Deny: keep the shortfall for the retry delay
            short_d = tbrl_pkg::AMOUNT_W'(CMP_W'(in_i.amount) - CMP_W'(bucket_q));
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        prod_d = tbrl_pkg::PROD_W'(short_q) * tbrl_pkg::PROD_W'(interval_q);
        if (refill_q == '0) begin
          out_valid_d = 1'b1;
          granted_d   = 1'b0;
          retry_d     = tbrl_pkg::RETRY_MAX;
          level_d     = level_of(bucket_q);
          state_d     = ST_IDLE;
        end else begin
          div_start_d = 1'b1;
          state_d     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          // Saturate the quotient and raise it to the minimum delay
          if (|div_rsp.quotient[tbrl_pkg::DIV_W-1:tbrl_pkg::RETRY_W]) begin
            retry_d = tbrl_pkg::RETRY_MAX;
          end else if (div_rsp.quotient[tbrl_pkg::RETRY_W-1:0] <
                       tbrl_pkg::RETRY_W'(min_retry_q)) begin
            retry_d = tbrl_pkg::RETRY_W'(min_retry_q);
          end else begin
            retry_d = div_rsp.quotient[tbrl_pkg::RETRY_W-1:0];
          end
          out_valid_d = 1'b1;
          granted_d   = 1'b0;
          level_d     = level_of(bucket_q);
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State, bucket, registers and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bucket_q    <= '0;
      elapsed_q   <= '0;
      limit_q     <= tbrl_pkg::LIMIT_RST;
      refill_q    <= tbrl_pkg::REFILL_RST;
      interval_q  <= tbrl_pkg::INTERVAL_RST;
      min_retry_q <= tbrl_pkg::MIN_RETRY_RST;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
      granted_q   <= 1'b0;
      retry_q     <= '0;
      level_q     <= '0;
    end else begin
      state_q     <= state_d;
      bucket_q    <= bucket_d;
      elapsed_q   <= elapsed_d;
      limit_q     <= limit_d;
      refill_q    <= refill_d;
      interval_q  <= interval_d;
      min_retry_q <= min_retry_d;
      div_start_q <= div_start_d;
      out_valid_q <= out_valid_d;
      granted_q   <= granted_d;
      retry_q     <= retry_d;
      level_q     <= level_d;
    end
  end

  // Hold the retry operands
  always_ff @(posedge clk_i) begin
    short_q <= short_d;
    prod_q  <= prod_d;
  end

  assign div_req.start    = div_start_q;
  assign div_req.dividend = tbrl_pkg::DIV_W'(prod_q);
  assign div_req.divisor  = refill_q;

  tbrl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.granted     = granted_q;
  assign out_o.retry_after = retry_q;
  assign out_o.level       = level_q;

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide phase");

  a_out_free_at_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> !out_valid_q)
    else $error("result register busy when the retry delay is ready");

  a_bucket_held_deny: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && !cfg_we_i) |=> $stable(bucket_q))
    else $error("bucket changed while a denied request is pending");

  a_grant_no_retry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && granted_q) |-> (retry_q == '0))
    else $error("granted result carries a retry delay");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench: token bucket rate limiter unit
// Sends ticks and token requests over the valid/ready input channel and
// checks each grant decision, retry delay and bucket level against fixed
// values or an in-bench bucket predictor. A short directed walk covers reset values,
// field extremes, zero refill, zero interval, a lowered interval, a bucket
// above its cap and an unused register index. Random phases follow under
// several register settings and idle patterns, one of them with a long
// result-side hold-off that backs the block up.
// ============================================================================
module testbench;
  import tbrl_pkg::*;

  localparam int                   ITEMS_PER_PHASE = 380;
  localparam int                   PHASES          = 5;
  localparam int                   HOLD_CYCLES     = 400;
  localparam int                   DRAIN_CYCLES    = 40;
  localparam int                   CYCLE_LIMIT     = 1000000;
  localparam int                   RESET_CYCLES    = 9;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED      = 3'd7;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic                      granted;
    logic [RETRY_W-1:0]        retry;
    logic signed [LEVEL_W-1:0] level;
  } decision_t;

  typedef struct {
    logic                  is_write;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  kind;
    logic [AMOUNT_W-1:0]   amount;
    logic                  typed;
    decision_t             want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tbrl_in_if  in_ch ();
  tbrl_out_if out_ch ();

  token_bucket_rate_limiter_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // Bucket predictor state and register copies
  logic [63:0] lvl_tokens;
  logic [31:0] ticks_into_interval;
  logic [63:0] cap_tokens;
  logic [63:0] refill_tokens;
  logic [63:0] interval_len;
  logic [63:0] retry_floor;

  decision_t   due_decisions [$];
  plan_row_t   directed_rows [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_asks      = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;
  int unsigned mismatch_cnt   = 0;
  int unsigned result_cnt     = 0;
  int unsigned cycle_cnt      = 0;
  decision_t   seen_dec;
  decision_t   due_dec;

  idle_mode_e  phase_mode [PHASES] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE};

  always #10 clk = ~clk;

  // Advance the bucket by one item and return the decision it yields
  function automatic decision_t next_decision(input logic kind,
                                              input logic [AMOUNT_W-1:0] amount);
    decision_t   d;
    logic [63:0] topped;
    logic [63:0] delay;
    d = '0;
    if (kind == KIND_TICK) begin
      ticks_into_interval = ticks_into_interval + 32'd1;
      // zero interval refills every tick; a lowered interval refills on the next one
      if (ticks_into_interval >= interval_len || ticks_into_interval == '0) begin
        ticks_into_interval = '0;
        // leave a bucket above its cap as it is
        if (lvl_tokens <= cap_tokens) begin
          topped = lvl_tokens + refill_tokens;
          if (topped > cap_tokens) topped = cap_tokens;
          if (topped > 64'(TOKEN_MAX)) topped = 64'(TOKEN_MAX);
          if (topped > lvl_tokens) lvl_tokens = topped;
        end
      end
    end else if (64'(amount) <= lvl_tokens) begin
      lvl_tokens = lvl_tokens - 64'(amount);
      d.granted  = 1'b1;
    end else begin
      // shortfall over the refill rate, floored and saturated
      if (refill_tokens == '0) begin
        delay = 64'(RETRY_MAX);
      end else begin
        delay = ((64'(amount) - lvl_tokens) * interval_len) / refill_tokens;
        if (delay < retry_floor) delay = retry_floor;
      end
      if (delay > 64'(RETRY_MAX)) delay = 64'(RETRY_MAX);
      d.retry = delay[RETRY_W-1:0];
    end
    d.level = lvl_tokens[LEVEL_W-1:0];
    return d;
  endfunction

  function automatic void plan_write(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r          = '{default: '0};
    r.is_write = 1'b1;
    r.idx      = idx;
    r.data     = data;
    directed_rows.push_back(r);
  endfunction

  function automatic void plan_item(input logic kind, input logic [AMOUNT_W-1:0] amount,
                                    input logic typed, input logic granted,
                                    input logic [RETRY_W-1:0] retry,
                                    input logic signed [LEVEL_W-1:0] level);
    plan_row_t r;
    r              = '{default: '0};
    r.kind         = kind;
    r.amount       = amount;
    r.typed        = typed;
    r.want.granted = granted;
    r.want.retry   = retry;
    r.want.level   = level;
    directed_rows.push_back(r);
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%s", msg);
  endfunction

  // Write one register and mirror it into the predictor
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_INITIAL_LEVEL: begin
        lvl_tokens = 64'(data[INIT_W-1:0]);
        if (lvl_tokens > 64'(TOKEN_MAX)) lvl_tokens = 64'(TOKEN_MAX);
      end
      CFG_BUCKET_LIMIT:    cap_tokens    = 64'(data[LIMIT_W-1:0]);
      CFG_REFILL_AMOUNT:   refill_tokens = 64'(data[REFILL_W-1:0]);
      CFG_INTERVAL_TICKS:  interval_len  = 64'(data[INTERVAL_W-1:0]);
      CFG_MIN_RETRY_TICKS: retry_floor   = 64'(data[MIN_RETRY_W-1:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Offer one item, hold it until the transfer, then log its expected decision
  task automatic offer_item(input logic kind, input logic [AMOUNT_W-1:0] amount,
                            input logic typed, input decision_t want);
    decision_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.kind   <= kind;
    in_ch.amount <= amount;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pred = next_decision(kind, amount);
    due_decisions.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  // Drop valid and wait for the block to drain
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (due_decisions.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Register setting for one random phase
  task automatic load_setting(input int ph);
    logic [CFG_DATA_W-1:0] lim_v;
    logic [CFG_DATA_W-1:0] add_v;
    logic [CFG_DATA_W-1:0] ivl_v;
    logic [CFG_DATA_W-1:0] min_v;
    logic [CFG_DATA_W-1:0] init_v;
    case (ph)
      0: begin
        lim_v = 200; add_v = 7; ivl_v = 3; min_v = 0; init_v = 100;
      end
      1: begin
        lim_v  = 32'h7FFF_FFFF;
        add_v  = 32'h0000_FFFF;
        ivl_v  = 1;
        min_v  = $urandom_range(0, 50);
        init_v = $urandom_range(0, 1000);
      end
      2: begin
        lim_v  = $urandom_range(16, 500);
        add_v  = $urandom_range(1, 40);
        ivl_v  = $urandom_range(1, 8);
        min_v  = 32'hFFFF_FFFF;
        init_v = 0;
      end
      3: begin
        lim_v = 0; add_v = 0; ivl_v = 0; min_v = 0;
        init_v = $urandom_range(0, 300);
      end
      default: begin
        lim_v  = $urandom_range(100, 2000);
        add_v  = $urandom_range(1, 100);
        ivl_v  = $urandom_range(2, 20);
        min_v  = $urandom_range(0, 1000);
        init_v = $urandom_range(0, lim_v);
      end
    endcase
    write_reg(CFG_BUCKET_LIMIT, lim_v);
    write_reg(CFG_REFILL_AMOUNT, add_v);
    write_reg(CFG_INTERVAL_TICKS, ivl_v);
    write_reg(CFG_MIN_RETRY_TICKS, min_v);
    write_reg(CFG_INITIAL_LEVEL, init_v);
  endtask

  // Drive result-side ready: long hold-off on request, else random stalls
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left    = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_seen != hold_asks) begin
      hold_seen    = hold_asks;
      hold_left    = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Check every result transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      seen_dec.granted = out_ch.granted;
      seen_dec.retry   = out_ch.retry_after;
      seen_dec.level   = out_ch.level;
      result_cnt++;
      if (due_decisions.size() == 0) begin
        note_mismatch($sformatf("result %0d with none expected: granted=%0d retry=%0d level=%0d",
                                result_cnt, seen_dec.granted, seen_dec.retry, seen_dec.level));
      end else begin
        due_dec = due_decisions.pop_front();
        if (seen_dec.granted !== due_dec.granted || seen_dec.retry !== due_dec.retry ||
            seen_dec.level !== due_dec.level) begin
          note_mismatch($sformatf({"result %0d: expected granted=%0d retry=%0d level=%0d,",
                                   " got granted=%0d retry=%0d level=%0d"},
                                  result_cnt, due_dec.granted, due_dec.retry, due_dec.level,
                                  seen_dec.granted, seen_dec.retry, seen_dec.level));
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    plan_row_t           row;
    logic                quiet;
    logic                kind;
    logic [AMOUNT_W-1:0] amount;
    logic [31:0]         span;
    int unsigned         roll;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.kind   = KIND_TICK;
    in_ch.amount = '0;
    out_ch.ready = 1'b0;

    lvl_tokens          = '0;
    ticks_into_interval = '0;
    cap_tokens          = 64'(LIMIT_RST);
    refill_tokens       = 64'(REFILL_RST);
    interval_len        = 64'(INTERVAL_RST);
    retry_floor         = 64'(MIN_RETRY_RST);

    // Directed walk: reset values first, then extremes and corner settings
    plan_item(KIND_REQUEST, 31'd0, 1'b1, 1'b1, 48'd0, 32'sd0);
    plan_item(KIND_REQUEST, 31'd1, 1'b1, 1'b0, 48'd1000, 32'sd0);
    plan_item(KIND_TICK, 31'h7FFF_FFFF, 1'b1, 1'b0, 48'd0, 32'sd0);
    plan_item(KIND_REQUEST, 31'h7FFF_FFFF, 1'b1, 1'b0, 48'd2147483647000, 32'sd0);
    plan_write(CFG_INITIAL_LEVEL, 32'h7FFF_FFFF);
    plan_item(KIND_REQUEST, 31'h7FFF_FFFF, 1'b1, 1'b1, 48'd0, 32'sd0);
    // bucket above its cap, zero interval
    plan_write(CFG_INITIAL_LEVEL, 32'd2000);
    plan_write(CFG_INTERVAL_TICKS, 32'd0);
    plan_item(KIND_TICK, 31'd0, 1'b1, 1'b0, 48'd0, 32'sd2000);
    // refill stops at the cap
    plan_write(CFG_INITIAL_LEVEL, 32'd1020);
    plan_write(CFG_REFILL_AMOUNT, 32'h0000_FFFF);
    plan_item(KIND_TICK, 31'd0, 1'b1, 1'b0, 48'd0, 32'sd1024);
    // zero refill: saturated delay, no growth
    plan_write(CFG_REFILL_AMOUNT, 32'd0);
    plan_item(KIND_REQUEST, 31'd2000, 1'b1, 1'b0, RETRY_MAX, 32'sd1024);
    plan_item(KIND_TICK, 31'd0, 1'b1, 1'b0, 48'd0, 32'sd1024);
    // floor raises the delay, then a huge product saturates
    plan_write(CFG_REFILL_AMOUNT, 32'd3);
    plan_write(CFG_INTERVAL_TICKS, 32'hFFFF_FFFF);
    plan_write(CFG_MIN_RETRY_TICKS, 32'hFFFF_FFFF);
    plan_item(KIND_REQUEST, 31'd1025, 1'b0, 1'b0, 48'd0, 32'sd0);
    plan_write(CFG_MIN_RETRY_TICKS, 32'd0);
    plan_write(CFG_BUCKET_LIMIT, 32'h7FFF_FFFF);
    plan_write(CFG_INITIAL_LEVEL, 32'd0);
    plan_item(KIND_REQUEST, 31'h7FFF_FFFF, 1'b0, 1'b0, 48'd0, 32'sd0);
    // interval lowered below the elapsed count
    plan_item(KIND_TICK, 31'd0, 1'b0, 1'b0, 48'd0, 32'sd0);
    plan_item(KIND_TICK, 31'h2AAA_AAAA, 1'b0, 1'b0, 48'd0, 32'sd0);
    plan_item(KIND_TICK, 31'h5555_5555, 1'b0, 1'b0, 48'd0, 32'sd0);
    plan_write(CFG_INTERVAL_TICKS, 32'd2);
    plan_item(KIND_TICK, 31'd0, 1'b0, 1'b0, 48'd0, 32'sd0);
    // write to an unused index must change nothing
    plan_write(CFG_UNUSED, 32'hFFFF_FFFF);
    plan_item(KIND_REQUEST, 31'd3, 1'b0, 1'b0, 48'd0, 32'sd0);
    // zero cap blocks refill, small delay lifted to the floor
    plan_write(CFG_BUCKET_LIMIT, 32'd0);
    plan_write(CFG_MIN_RETRY_TICKS, 32'd5);
    plan_item(KIND_TICK, 31'd0, 1'b0, 1'b0, 48'd0, 32'sd0);
    plan_item(KIND_TICK, 31'd0, 1'b0, 1'b0, 48'd0, 32'sd0);
    plan_item(KIND_REQUEST, 31'd1, 1'b0, 1'b0, 48'd0, 32'sd0);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed rows, draining before each run of writes
    quiet = 1'b1;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_write) begin
        if (!quiet) settle();
        quiet = 1'b1;
        write_reg(row.idx, row.data);
      end else begin
        quiet = 1'b0;
        offer_item(row.kind, row.amount, row.typed, row.want);
      end
    end

    // Random phases: mostly requests sized around the current bucket
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      load_setting(ph);
      case (phase_mode[ph])
        IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        IDLE_SEND: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        IDLE_BOTH: begin send_idle_pct = 24; recv_stall_pct = 24; end
        default: ;
      endcase
      // last phase: hold results off long enough to back up the input
      if (ph == PHASES - 1) hold_asks = hold_asks + 1;
      repeat (ITEMS_PER_PHASE) begin
        roll   = $urandom_range(0, 99);
        span   = (lvl_tokens > 64'd268435456) ? 32'd268435456 : lvl_tokens[31:0];
        amount = AMOUNT_W'($urandom());
        if (roll < 45) begin
          kind = KIND_TICK;
        end else begin
          kind = KIND_REQUEST;
          if (roll < 88) amount = AMOUNT_W'($urandom_range(0, span + span / 4 + 4));
          else if (roll < 95) amount = AMOUNT_W'($urandom_range(0, 32'h000F_FFFF));
        end
        offer_item(kind, amount, 1'b0, '0);
      end
    end

    settle();
    if (mismatch_cnt == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
